// ===== hw/rtl/cobs_enc_pkg.sv =====
// Shared types and constants for the COBS frame encoder.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package cobs_enc_pkg;

	localparam int CAP_W   = 13;
	localparam int ADDR_W  = 12;
	localparam int POS_W   = 13;
	localparam int CODE_W  = 8;
	localparam int BYTE_W  = 8;
	localparam int PHASE_W = 8;

	localparam logic [CAP_W-1:0]   CAP_RESET  = 13'd4096;
	localparam logic [CODE_W-1:0]  FULL_CODE  = 8'hFF;
	localparam logic [PHASE_W-1:0] BLOCK_SPAN = 8'd254;

	// Configuration register indexes
	localparam logic REG_OUT_CAPACITY = 1'b0;

	// Result queue
	localparam int MAX_RESULTS = 3;
	localparam int Q_DEPTH     = 4;
	localparam int Q_PTR_W     = 2;
	localparam int Q_CNT_W     = 3;
	localparam int RES_CNT_W   = 2;

	typedef struct packed {
		logic [ADDR_W-1:0] write_addr;
		logic [BYTE_W-1:0] write_value;
		logic              run_end;
		logic              frame_done;
		logic [POS_W-1:0]  frame_length;
		logic              error;
	} result_t;

	typedef struct packed {
		result_t [MAX_RESULTS-1:0] res;
		logic [RES_CNT_W-1:0]      count;
	} step_out_t;

endpackage

// ===== hw/rtl/cobs_enc_ifs.sv =====
// Stream channel interfaces of the COBS frame encoder: raw bytes in,
// addressed buffer writes out. Depends on cobs_enc_pkg.
`timescale 1ns / 1ps

interface cobs_in_if import cobs_enc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              last_in;

	modport source (output valid, output data_byte, output last_in, input ready);
	modport sink   (input valid, input data_byte, input last_in, output ready);
endinterface

interface cobs_out_if import cobs_enc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] write_addr;
	logic [BYTE_W-1:0] write_value;
	logic              run_end;
	logic              frame_done;
	logic [POS_W-1:0]  frame_length;
	logic              error;

	modport source (output valid, output write_addr, output write_value, output run_end,
		output frame_done, output frame_length, output error, input ready);
	modport sink   (input valid, input write_addr, input write_value, input run_end,
		input frame_done, input frame_length, input error, output ready);
endinterface

// ===== hw/rtl/cobs_enc_step.sv =====
// Encoder state and per-byte step logic: block code tracking, write
// positions and the running size bound. Depends on cobs_enc_pkg.
`timescale 1ns / 1ps

module cobs_enc_step import cobs_enc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              last_in,
	input  logic [CAP_W-1:0]  cap,
	output step_out_t         step_out
);

	logic [ADDR_W-1:0]  code_pos_q,    code_pos_d;
	logic [POS_W-1:0]   write_pos_q,   write_pos_d;
	logic [CODE_W-1:0]  run_code_q,    run_code_d;
	logic [CAP_W-1:0]   size_bound_q,  size_bound_d;
	logic [PHASE_W-1:0] bound_phase_q, bound_phase_d;
	logic               overflowed_q,  overflowed_d;

	logic               phase_wrap;
	logic [CAP_W:0]     bound_inc;
	logic               ovf;
	logic [CODE_W-1:0]  run_inc;
	logic [POS_W-1:0]   wp_inc;

	// One spare bit keeps the bound from wrapping when capacity is near full scale
	assign phase_wrap = bound_phase_q == (BLOCK_SPAN - 8'd1);
	assign bound_inc  = {1'b0, size_bound_q} + 14'd1 + {13'd0, phase_wrap};
	assign ovf        = overflowed_q || (bound_inc > {1'b0, cap});
	assign run_inc    = run_code_q + 8'd1;
	assign wp_inc     = write_pos_q + 13'd1;

	always_comb begin
		code_pos_d    = code_pos_q;
		write_pos_d   = write_pos_q;
		run_code_d    = run_code_q;
		size_bound_d  = size_bound_q;
		bound_phase_d = bound_phase_q;
		overflowed_d  = overflowed_q;
		step_out      = '0;

		if (!overflowed_q) begin
			size_bound_d  = bound_inc[CAP_W-1:0];
			bound_phase_d = phase_wrap ? '0 : bound_phase_q + 8'd1;
		end

		if (ovf) begin
			overflowed_d = 1'b1;
			if (last_in) begin
				step_out.res[0].run_end    = 1'b1;
				step_out.res[0].frame_done = 1'b1;
				step_out.res[0].error      = 1'b1;
				step_out.count             = 2'd1;
			end
		end else begin
			if (data_byte == '0) begin
				// zero byte: close the block at the saved code slot
				step_out.res[0].write_addr  = code_pos_q;
				step_out.res[0].write_value = run_code_q;
				code_pos_d  = write_pos_q[ADDR_W-1:0];
				write_pos_d = wp_inc;
				run_code_d  = 8'd1;
			end else begin
				step_out.res[0].write_addr  = write_pos_q[ADDR_W-1:0];
				step_out.res[0].write_value = data_byte;
				write_pos_d = wp_inc;
				run_code_d  = run_inc;
				if (run_inc == FULL_CODE) begin
					// full block: close it now and open a new code slot
					step_out.res[1].write_addr  = code_pos_q;
					step_out.res[1].write_value = FULL_CODE;
					code_pos_d  = wp_inc[ADDR_W-1:0];
					write_pos_d = write_pos_q + 13'd2;
					run_code_d  = 8'd1;
				end
			end
			step_out.count = (run_inc == FULL_CODE && data_byte != '0) ? 2'd2 : 2'd1;

			if (last_in) begin
				step_out.res[step_out.count].write_addr   = code_pos_d;
				step_out.res[step_out.count].write_value  = run_code_d;
				step_out.res[step_out.count].frame_done   = 1'b1;
				step_out.res[step_out.count].frame_length = write_pos_d;
				step_out.count = step_out.count + 2'd1;
			end
			step_out.res[step_out.count - 2'd1].run_end = 1'b1;
		end

		if (last_in) begin
			// frame finished: back to the empty-frame state
			code_pos_d    = '0;
			write_pos_d   = 13'd1;
			run_code_d    = 8'd1;
			size_bound_d  = 13'd1;
			bound_phase_d = '0;
			overflowed_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_pos_q    <= '0;
			write_pos_q   <= 13'd1;
			run_code_q    <= 8'd1;
			size_bound_q  <= 13'd1;
			bound_phase_q <= '0;
			overflowed_q  <= 1'b0;
		end else if (fire) begin
			code_pos_q    <= code_pos_d;
			write_pos_q   <= write_pos_d;
			run_code_q    <= run_code_d;
			size_bound_q  <= size_bound_d;
			bound_phase_q <= bound_phase_d;
			overflowed_q  <= overflowed_d;
		end
	end

endmodule

// ===== hw/rtl/cobs_enc_queue.sv =====
// Four-entry result queue: takes up to three results per cycle, hands
// out one per cycle while out_ready is high. Depends on cobs_enc_pkg.
`timescale 1ns / 1ps

module cobs_enc_queue import cobs_enc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [RES_CNT_W-1:0]      push_n,
	input  result_t [MAX_RESULTS-1:0] push_data,
	output logic                      room,
	output logic                      out_valid,
	input  logic                      out_ready,
	output result_t                   out_data
);

	result_t             entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_CNT_W-1:0]  count_q;
	logic                pop;

	// Room for a full burst of results, with no credit for this cycle's pop
	assign room      = count_q <= 3'd1;
	assign out_valid = count_q != '0;
	assign pop       = out_valid && out_ready;
	assign out_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (RES_CNT_W'(i) < push_n) begin
				entry_q[wr_ptr_q + Q_PTR_W'(i)] <= push_data[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_PTR_W'(push_n);
			rd_ptr_q <= rd_ptr_q + Q_PTR_W'(pop);
			count_q  <= count_q + Q_CNT_W'(push_n) - Q_CNT_W'(pop);
		end
	end

endmodule

// ===== hw/rtl/cobs_frame_encoder.sv =====
// Top level of the streaming COBS frame encoder: input register, config
// register, step logic and result queue. Depends on cobs_enc_pkg,
// cobs_enc_ifs, cobs_enc_step and cobs_enc_queue.
`timescale 1ns / 1ps

// Usage
//   in_ch carries one raw frame byte per transaction, last_in set on the
//   frame's final byte. out_ch carries addressed writes into the output frame
//   buffer: data bytes at the running position and block codes at the saved
//   code slot. run_end marks the last write caused by one input byte;
//   frame_done marks the closing code write and carries the encoded length,
//   or length 0 with error set when out_capacity was too small (writes then
//   stop for the rest of the frame).
//   out_capacity sits at APB address 0; write it only while the block is idle.
// Timing
//   An accepted byte waits in the input register until the queue has room,
//   then is processed and its writes are registered into the queue. Most
//   bytes leave one write, so bytes stream at one per cycle while out_ch
//   keeps up; a byte that closes a full block or ends an error-free frame
//   leaves two or three writes; input waits until one queue entry is left.
// Reset and stall
//   arst_n clears the encoder to the empty-frame state and sets out_capacity
//   to 4096. When out_ch stalls, writes hold in the queue and the input stage
//   stops once two writes are waiting.

module cobs_frame_encoder import cobs_enc_pkg::*; #(
	parameter int OUT_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	cobs_in_if.sink     in_ch,
	cobs_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int DEPTH_BITS = $clog2(OUT_DEPTH + 1);
	localparam int CMP_W      = (DEPTH_BITS > CAP_W) ? DEPTH_BITS : CAP_W;

	logic [CAP_W-1:0]  cap_q;
	logic [CAP_W-1:0]  cap_use;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	logic              room;
	logic              proc;
	step_out_t         step_out;
	logic [RES_CNT_W-1:0] push_n;
	result_t           head;

	// Configuration: one register, written on the APB access phase
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_OUT_CAPACITY) ? {19'd0, cap_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_OUT_CAPACITY) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// Limit the capacity to the buffer depth
	assign cap_use = (CMP_W'(cap_q) > CMP_W'(OUT_DEPTH)) ? CAP_W'(OUT_DEPTH) : cap_q;

	// Input stage: advance when the queue has room for a full burst
	assign proc        = valid_s1 && room;
	assign in_ch.ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.last_in;
		end
	end

	cobs_enc_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (proc),
		.data_byte (byte_s1),
		.last_in   (last_s1),
		.cap       (cap_use),
		.step_out  (step_out)
	);

	// Drop the results of a cycle that does not process
	assign push_n = proc ? step_out.count : '0;

	cobs_enc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_data (step_out.res),
		.room      (room),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_data  (head)
	);

	assign out_ch.write_addr   = head.write_addr;
	assign out_ch.write_value  = head.write_value;
	assign out_ch.run_end      = head.run_end;
	assign out_ch.frame_done   = head.frame_done;
	assign out_ch.frame_length = head.frame_length;
	assign out_ch.error        = head.error;

endmodule
